/* rtl/jkv_pkg.sv */
// Shared types and status codes of the JSON key/value extractor.
package jkv_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ABSENT  = 3'd1;
  localparam logic [2:0] ST_TYPE    = 3'd2;
  localparam logic [2:0] ST_UNTERM  = 3'd3;
  localparam logic [2:0] ST_ZEROCAP = 3'd4;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  string_char;
    logic [2:0]  status_code;
    logic [31:0] number_value;
  } result_t;

  // Everything one payload byte produces: one result, or a character and a status.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } bundle_t;

endpackage

/* rtl/jkv_in_if.sv */
// Handshake channel that carries payload bytes into the extractor.
interface jkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_last;

  modport source (output valid, output payload_byte, output payload_last, input ready);
  modport sink (input valid, input payload_byte, input payload_last, output ready);
endinterface

/* rtl/jkv_out_if.sv */
// Handshake channel that carries result items out of the extractor.
interface jkv_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  string_char;
  logic [2:0]  status_code;
  logic [31:0] number_value;

  modport source (output valid, output result_kind, output string_char,
                  output status_code, output number_value, input ready);
  modport sink (input valid, input result_kind, input string_char,
                input status_code, input number_value, output ready);
endinterface

/* rtl/jkv_key_match.sv */
// Compares the window of recent bytes against the quoted key.
module jkv_key_match #(
  parameter int MAX_KEY_CHARS = 16
) (
  input  logic [MAX_KEY_CHARS:0][7:0]           recent,
  input  logic [$clog2(MAX_KEY_CHARS + 2)-1:0]  bytes_seen,
  input  logic [4:0]                            klen,
  input  logic [63:0]                           key_chars_low,
  input  logic [63:0]                           key_chars_high,
  input  logic [7:0]                            cur_byte,
  output logic                                  hit
);

  localparam int WIN = MAX_KEY_CHARS + 1;
  localparam int IDX_W = $clog2(WIN);
  localparam logic [7:0] CH_QUOTE = 8'h22;

  logic [MAX_KEY_CHARS-1:0] char_ok;
  logic                     open_quote_ok;
  logic                     enough_bytes;

  always_comb begin
    logic [5:0] pos;
    logic [7:0] kc;
    for (int i = 0; i < MAX_KEY_CHARS; i++) begin
      pos = {1'b0, klen} - 6'd1 - 6'(i);
      kc = (i < 8) ? key_chars_low[8*(i%8) +: 8] : key_chars_high[8*(i%8) +: 8];
      // Characters beyond the key length do not take part.
      char_ok[i] = (6'(i) >= {1'b0, klen}) || (recent[pos[IDX_W-1:0]] == kc);
    end
  end

  assign open_quote_ok = recent[klen[IDX_W-1:0]] == CH_QUOTE;
  assign enough_bytes  = 6'(bytes_seen) >= ({1'b0, klen} + 6'd1);
  assign hit = (cur_byte == CH_QUOTE) && enough_bytes && open_quote_ok && (&char_ok);

endmodule

/* rtl/jkv_result_queue.sv */
// Two-entry queue of result bundles that drives the result channel.
module jkv_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jkv_pkg::bundle_t  push_data,
  output logic              space,
  jkv_out_if.source         result
);

  jkv_pkg::bundle_t slots [2];
  jkv_pkg::bundle_t head;
  jkv_pkg::result_t cur;
  logic [1:0]       count;
  logic             wr_ptr;
  logic             rd_ptr;
  logic             sub;
  logic             take;
  logic             pop;

  assign head  = slots[rd_ptr];
  assign cur   = sub ? head.res1 : head.res0;
  assign take  = result.valid && result.ready;
  assign pop   = take && (!head.two || sub);
  assign space = count != 2'd2;

  assign result.valid        = count != 2'd0;
  assign result.result_kind  = cur.result_kind;
  assign result.string_char  = cur.string_char;
  assign result.status_code  = cur.status_code;
  assign result.number_value = cur.number_value;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sub    <= 1'b0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        sub    <= 1'b0;
      end else if (take) begin
        sub <= 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("result queue written while full");

  a_second_only_in_pair: assert property (@(posedge clk) disable iff (rst)
    (result.valid && sub) |-> head.two)
    else $error("second result shown for a single-result bundle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

endmodule

/* rtl/json_key_value_extractor_unit.sv */
// Top level of the streaming JSON key/value extractor.
//
// The unit scans a payload that arrives one byte per transaction on the payload channel,
// finds the first quoted key equal to the configured key (followed by optional spaces,
// a colon and optional spaces) and extracts its value: an unsigned decimal integer that
// saturates at 2^32-1 in integer mode, or the characters of a quoted string in string
// mode, each sent as its own result transaction. Every payload ends with exactly one
// status result; a zero byte ends the payload early and the bytes after it are ignored
// up to the byte flagged last. The unit accepts one payload byte per clock cycle while the
// result queue has space: all per-byte work (key window compare, digit multiply-add, string
// bookkeeping) is combinational between the payload port and a two-entry result queue, and
// each result is registered into the queue when its byte is accepted. With the result
// side always ready, a byte that yields one result keeps pace at one result per cycle.
// The only byte that yields two results (a string character on the final byte, followed
// by its status) occupies the result side until both are taken, and the payload side may
// then have to wait. Payload ready drops whenever the queue holds two bundles, so stalls on
// the result channel back up into the payload channel. Configuration registers are
// written through the plain write port and take effect from the next byte.
module json_key_value_extractor_unit #(
  parameter int MAX_KEY_CHARS = 16,
  parameter int MAX_CAPACITY  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  jkv_in_if.sink      payload,
  jkv_out_if.source   result
);

  localparam int WIN    = MAX_KEY_CHARS + 1;
  localparam int SEEN_W = $clog2(WIN + 1);
  localparam int CC_W   = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;

  localparam logic [4:0]        KEY_MAX  = 5'(MAX_KEY_CHARS);
  localparam logic [8:0]        CAP_MAX  = 9'(MAX_CAPACITY);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WIN);

  // Configuration register indexes.
  localparam logic [2:0] REG_VALUE_MODE = 3'd0;
  localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
  localparam logic [2:0] REG_KEY_LOW    = 3'd2;
  localparam logic [2:0] REG_KEY_HIGH   = 3'd3;
  localparam logic [2:0] REG_CAPACITY   = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_VSTART,
    PH_INT,
    PH_STR,
    PH_DONE
  } phase_t;

  // Configuration registers.
  logic        value_mode;
  logic [4:0]  key_length;
  logic [63:0] key_chars_low;
  logic [63:0] key_chars_high;
  logic [8:0]  string_capacity;

  // Per-payload parse state; the window holds the newest byte at index 0.
  logic [WIN-1:0][7:0] recent;
  logic [SEEN_W-1:0]   bytes_seen;
  phase_t              phase;
  logic [31:0]         accumulator;
  logic [CC_W-1:0]     chars_copied;

  phase_t              phase_next;
  logic [31:0]         accumulator_next;
  logic [CC_W-1:0]     chars_copied_next;

  logic [4:0]  klen;
  logic [8:0]  cap;
  logic        key_hit;
  logic        accept;
  logic        queue_space;
  logic [7:0]  b;
  logic        is_zero;
  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] mac;
  logic [31:0] mac_sat;
  logic        payload_end;

  phase_t              ph_p;
  logic [31:0]         acc_p;
  logic [CC_W-1:0]     cc_p;
  logic                proc_emit;
  jkv_pkg::result_t    proc_res;
  phase_t              ph_f;
  logic [31:0]         acc_f;
  logic                fin_emit;
  jkv_pkg::result_t    fin_res;
  jkv_pkg::bundle_t    bundle;

  // Out-of-range key lengths and capacities are clamped.
  always_comb begin
    if (key_length == 5'd0) begin
      klen = 5'd1;
    end else if (key_length > KEY_MAX) begin
      klen = KEY_MAX;
    end else begin
      klen = key_length;
    end
    cap = (string_capacity > CAP_MAX) ? CAP_MAX : string_capacity;
  end

  assign b           = payload.payload_byte;
  assign is_zero     = b == 8'd0;
  assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit       = 4'(b - CH_ZERO);
  assign accept      = payload.valid && queue_space;
  assign payload.ready = queue_space;
  assign payload_end = is_zero || payload.payload_last;

  // Decimal step: accumulator * 10 + digit, saturating at the 32-bit maximum.
  assign mac     = ({4'd0, accumulator} << 3) + ({4'd0, accumulator} << 1) + 36'(digit);
  assign mac_sat = (|mac[35:32]) ? 32'hFFFF_FFFF : mac[31:0];

  jkv_key_match #(
    .MAX_KEY_CHARS (MAX_KEY_CHARS)
  ) u_key_match (
    .recent         (recent),
    .bytes_seen     (bytes_seen),
    .klen           (klen),
    .key_chars_low  (key_chars_low),
    .key_chars_high (key_chars_high),
    .cur_byte       (b),
    .hit            (key_hit)
  );

  // Byte processing for a nonzero byte.
  always_comb begin
    ph_p      = phase;
    acc_p     = accumulator;
    cc_p      = chars_copied;
    proc_emit = 1'b0;
    proc_res  = '{result_kind: jkv_pkg::KIND_STATUS, string_char: 8'd0,
                  status_code: jkv_pkg::ST_OK, number_value: 32'd0};
    case (phase)
      PH_SEARCH: begin
        ph_p = key_hit ? PH_COLON : PH_SEARCH;
      end
      PH_COLON: begin
        if (b == CH_COLON) begin
          ph_p = PH_VSTART;
        end else if (b != CH_SPACE) begin
          // A failed candidate: this byte is searched again as an ordinary byte.
          ph_p = key_hit ? PH_COLON : PH_SEARCH;
        end
      end
      PH_VSTART: begin
        if (b != CH_SPACE) begin
          if (!value_mode) begin
            if (is_digit) begin
              acc_p = 32'(digit);
              ph_p  = PH_INT;
            end else begin
              proc_emit            = 1'b1;
              proc_res.status_code = jkv_pkg::ST_TYPE;
              ph_p                 = PH_DONE;
            end
          end else if (b != CH_QUOTE) begin
            proc_emit            = 1'b1;
            proc_res.status_code = jkv_pkg::ST_TYPE;
            ph_p                 = PH_DONE;
          end else if (cap == 9'd0) begin
            proc_emit            = 1'b1;
            proc_res.status_code = jkv_pkg::ST_ZEROCAP;
            ph_p                 = PH_DONE;
          end else begin
            cc_p = '0;
            ph_p = PH_STR;
          end
        end
      end
      PH_INT: begin
        if (is_digit) begin
          acc_p = mac_sat;
        end else begin
          proc_emit             = 1'b1;
          proc_res.number_value = accumulator;
          ph_p                  = PH_DONE;
        end
      end
      PH_STR: begin
        if (b == CH_QUOTE) begin
          proc_emit = 1'b1;
          ph_p      = PH_DONE;
        end else if ((10'(chars_copied) + 10'd1) < {1'b0, cap}) begin
          proc_emit            = 1'b1;
          proc_res.result_kind = jkv_pkg::KIND_CHAR;
          proc_res.string_char = b;
          cc_p                 = chars_copied + 1'b1;
        end else begin
          proc_emit            = 1'b1;
          proc_res.status_code = jkv_pkg::ST_UNTERM;
          ph_p                 = PH_DONE;
        end
      end
      default: begin
        ph_p = phase;
      end
    endcase
  end

  // Status owed at the end of the payload, from the phase after this byte (for a zero byte, the phase before it).
  assign ph_f  = is_zero ? phase : ph_p;
  assign acc_f = is_zero ? accumulator : acc_p;

  always_comb begin
    fin_emit = 1'b1;
    fin_res  = '{result_kind: jkv_pkg::KIND_STATUS, string_char: 8'd0,
                 status_code: jkv_pkg::ST_OK, number_value: 32'd0};
    case (ph_f)
      PH_SEARCH, PH_COLON: fin_res.status_code = jkv_pkg::ST_ABSENT;
      PH_VSTART:           fin_res.status_code = jkv_pkg::ST_TYPE;
      PH_INT:              fin_res.number_value = acc_f;
      PH_STR:              fin_res.status_code = jkv_pkg::ST_UNTERM;
      default:             fin_emit = 1'b0;
    endcase
  end

  always_comb begin
    logic p_em;
    logic f_em;
    p_em        = proc_emit && !is_zero;
    f_em        = fin_emit && payload_end;
    bundle.two  = p_em && f_em;
    bundle.res0 = p_em ? proc_res : fin_res;
    bundle.res1 = fin_res;
  end

  always_comb begin
    if (payload_end) begin
      phase_next        = (is_zero && !payload.payload_last) ? PH_DONE : PH_SEARCH;
      accumulator_next  = 32'd0;
      chars_copied_next = '0;
    end else begin
      phase_next        = ph_p;
      accumulator_next  = acc_p;
      chars_copied_next = cc_p;
    end
  end

  jkv_result_queue u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && ((proc_emit && !is_zero) || (fin_emit && payload_end))),
    .push_data (bundle),
    .space     (queue_space),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      value_mode      <= 1'b0;
      key_length      <= 5'd1;
      key_chars_low   <= 64'd0;
      key_chars_high  <= 64'd0;
      string_capacity <= 9'd256;
      recent          <= '0;
      bytes_seen      <= '0;
      phase           <= PH_SEARCH;
      accumulator     <= 32'd0;
      chars_copied    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_VALUE_MODE: value_mode      <= cfg_data[0];
          REG_KEY_LENGTH: key_length      <= cfg_data[4:0];
          REG_KEY_LOW:    key_chars_low   <= cfg_data;
          REG_KEY_HIGH:   key_chars_high  <= cfg_data;
          REG_CAPACITY:   string_capacity <= cfg_data[8:0];
          default:        ;
        endcase
      end
      if (accept) begin
        phase        <= phase_next;
        accumulator  <= accumulator_next;
        chars_copied <= chars_copied_next;
        if (payload_end) begin
          recent     <= '0;
          bytes_seen <= '0;
        end else begin
          recent <= {recent[WIN-2:0], b};
          if (bytes_seen < SEEN_MAX) begin
            bytes_seen <= bytes_seen + 1'b1;
          end
        end
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && payload.payload_last) |=> (phase == PH_SEARCH) && (bytes_seen == '0))
    else $error("parse state not cleared after the final byte");

  a_search_acc_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SEARCH) |-> (accumulator == 32'd0))
    else $error("accumulator nonzero while searching for the key");

  a_zero_byte_status: assert property (@(posedge clk) disable iff (rst)
    (accept && is_zero && (phase != PH_DONE)) |-> u_result_queue.push)
    else $error("zero byte ended an open payload without a status");

endmodule

/* test/json_key_value_extractor_unit_test.sv */
// Self-checking testbench of the JSON key/value extractor: directed plan, then random payloads.
module json_key_value_extractor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_VALUE_MODE = 3'd0;
  localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
  localparam logic [2:0] REG_KEY_LOW    = 3'd2;
  localparam logic [2:0] REG_KEY_HIGH   = 3'd3;
  localparam logic [2:0] REG_CAPACITY   = 3'd4;

  localparam int KEY_CHARS_MAX  = 16;
  localparam int CAPACITY_MAX   = 256;
  localparam int WINDOW_DEPTH   = KEY_CHARS_MAX + 1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_MAX       = 17;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    SCAN, AFTER_KEY, VALUE_START, IN_NUMBER, IN_STRING, SETTLED
  } scan_phase_t;

  typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

  // One row of the directed plan: either a register write or a payload byte. A byte row may
  // carry the status it must produce, typed in by hand; otherwise the predictor decides.
  typedef struct packed {
    row_kind_t        kind;
    logic [2:0]       reg_index;
    logic [63:0]      reg_value;
    logic [7:0]       data;
    logic             last;
    logic             typed;
    jkv_pkg::result_t want;
  } plan_row_t;

  localparam jkv_pkg::result_t NO_RESULT      = '0;
  localparam jkv_pkg::result_t ANSWER_ABSENT  =
    '{jkv_pkg::KIND_STATUS, 8'h00, jkv_pkg::ST_ABSENT, 32'd0};
  localparam jkv_pkg::result_t ANSWER_FIVE    =
    '{jkv_pkg::KIND_STATUS, 8'h00, jkv_pkg::ST_OK, 32'd5};
  localparam jkv_pkg::result_t ANSWER_TYPE    =
    '{jkv_pkg::KIND_STATUS, 8'h00, jkv_pkg::ST_TYPE, 32'd0};
  localparam jkv_pkg::result_t ANSWER_ZEROCAP =
    '{jkv_pkg::KIND_STATUS, 8'h00, jkv_pkg::ST_ZEROCAP, 32'd0};
  localparam jkv_pkg::result_t ANSWER_UNTERM  =
    '{jkv_pkg::KIND_STATUS, 8'h00, jkv_pkg::ST_UNTERM, 32'd0};

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  jkv_in_if  payload_ch ();
  jkv_out_if result_ch ();

  json_key_value_extractor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .payload   (payload_ch),
    .result    (result_ch)
  );

  // Directed plan. It starts with the reset configuration (key of one zero character, so
  // nothing can match), covers a zero byte that ends a payload early with the rest ignored,
  // then an integer value, an empty value, a quote at zero capacity and a string that runs
  // past its capacity.
  plan_row_t plan [30] = '{
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "a",      1'b1, 1'b1, ANSWER_ABSENT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_NUL,   1'b0, 1'b1, ANSWER_ABSENT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  8'hff,    1'b1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_KEY_LENGTH, 64'd1,  CH_NUL,   1'b0, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_KEY_LOW,    64'h6b, CH_NUL,   1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "k",      1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_COLON, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "5",      1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "x",      1'b1, 1'b1, ANSWER_FIVE},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "k",      1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_COLON, 1'b1, 1'b1, ANSWER_TYPE},
    '{ROW_WRITE, REG_VALUE_MODE, 64'd1,  CH_NUL,   1'b0, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_CAPACITY,   64'd0,  CH_NUL,   1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "k",      1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_COLON, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b1, 1'b1, ANSWER_ZEROCAP},
    '{ROW_WRITE, REG_CAPACITY,   64'd2,  CH_NUL,   1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "k",      1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_COLON, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  CH_QUOTE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "a",      1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,  REG_VALUE_MODE, 64'd0,  "b",      1'b1, 1'b1, ANSWER_UNTERM}
  };

  // Shadow copy of the configuration registers, masked to their widths.
  logic        cfg_mode;
  logic [4:0]  cfg_key_len;
  logic [63:0] cfg_key_lo;
  logic [63:0] cfg_key_hi;
  logic [8:0]  cfg_capacity;

  // Predictor state for the payload in progress.
  logic [7:0]  key_window [WINDOW_DEPTH];
  int          window_fill;
  scan_phase_t scan_phase;
  logic [31:0] number_acc;
  int          copied_count;

  jkv_pkg::result_t step_results [$];   // what the byte just accepted produces
  jkv_pkg::result_t awaited [$];        // results the block still owes, oldest first
  logic [7:0]       outgoing [$];       // bytes of the random payload being sent

  logic             row_typed;
  jkv_pkg::result_t row_want;
  logic             source_burst;
  logic             sink_burst;
  int               mismatch_count = 0;
  int               random_items;
  int               idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  function automatic int key_span();
    int k;
    k = cfg_key_len;
    if (k == 0) k = 1;
    if (k > KEY_CHARS_MAX) k = KEY_CHARS_MAX;
    return k;
  endfunction

  function automatic int capacity_span();
    return (cfg_capacity > CAPACITY_MAX) ? CAPACITY_MAX : int'(cfg_capacity);
  endfunction

  function automatic logic [7:0] key_byte(input int i);
    if (i < 8) return cfg_key_lo[8*i +: 8];
    return cfg_key_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // A quote closes the key when the window holds an opening quote followed by the key.
  function automatic logic key_closes(input logic [7:0] b);
    int k;
    int i;
    k = key_span();
    if (b != CH_QUOTE || window_fill < k + 1) return 1'b0;
    if (key_window[k] != CH_QUOTE) return 1'b0;
    for (i = 0; i < k; i++)
      if (key_window[k-1-i] != key_byte(i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_payload();
    int i;
    for (i = 0; i < WINDOW_DEPTH; i++) key_window[i] = 8'h00;
    window_fill  = 0;
    scan_phase   = SCAN;
    number_acc   = 32'd0;
    copied_count = 0;
  endfunction

  function automatic void shift_in(input logic [7:0] b);
    int i;
    for (i = WINDOW_DEPTH - 1; i > 0; i--) key_window[i] = key_window[i-1];
    key_window[0] = b;
    if (window_fill < WINDOW_DEPTH) window_fill++;
  endfunction

  function automatic void settle_with(input logic [2:0] code, input logic [31:0] value);
    step_results.push_back('{jkv_pkg::KIND_STATUS, 8'h00, code, value});
    scan_phase = SETTLED;
  endfunction

  // Status owed when the payload ends before one was given.
  function automatic void close_payload();
    case (scan_phase)
      SCAN, AFTER_KEY: step_results.push_back(ANSWER_ABSENT);
      VALUE_START:     step_results.push_back(ANSWER_TYPE);
      IN_NUMBER:       step_results.push_back('{jkv_pkg::KIND_STATUS, 8'h00, jkv_pkg::ST_OK,
                                                number_acc});
      IN_STRING:       step_results.push_back(ANSWER_UNTERM);
      default: ;
    endcase
  endfunction

  function automatic void consume(input logic [7:0] b);
    logic [63:0] wide;
    case (scan_phase)
      AFTER_KEY: begin
        if (b != CH_SPACE) begin
          if (b == CH_COLON) scan_phase = VALUE_START;
          else scan_phase = key_closes(b) ? AFTER_KEY : SCAN;
        end
      end
      VALUE_START: begin
        if (b != CH_SPACE) begin
          if (!cfg_mode) begin
            if (is_digit(b)) begin
              number_acc = 32'(b - CH_ZERO);
              scan_phase = IN_NUMBER;
            end else begin
              settle_with(jkv_pkg::ST_TYPE, 32'd0);
            end
          end else if (b != CH_QUOTE) begin
            settle_with(jkv_pkg::ST_TYPE, 32'd0);
          end else if (capacity_span() == 0) begin
            settle_with(jkv_pkg::ST_ZEROCAP, 32'd0);
          end else begin
            copied_count = 0;
            scan_phase = IN_STRING;
          end
        end
      end
      IN_NUMBER: begin
        if (is_digit(b)) begin
          wide = 64'(number_acc) * 64'd10 + 64'(b - CH_ZERO);
          number_acc = (wide > 64'hffff_ffff) ? 32'hffff_ffff : wide[31:0];
        end else begin
          settle_with(jkv_pkg::ST_OK, number_acc);
        end
      end
      IN_STRING: begin
        if (b == CH_QUOTE) begin
          settle_with(jkv_pkg::ST_OK, 32'd0);
        end else if (copied_count + 1 < capacity_span()) begin
          step_results.push_back('{jkv_pkg::KIND_CHAR, b, jkv_pkg::ST_OK, 32'd0});
          copied_count++;
        end else begin
          settle_with(jkv_pkg::ST_UNTERM, 32'd0);
        end
      end
      SETTLED: ;
      default: scan_phase = key_closes(b) ? AFTER_KEY : SCAN;
    endcase
    shift_in(b);
  endfunction

  // Works out every result one accepted payload byte causes, in order.
  function automatic void extractor_step(input logic [7:0] b, input logic last);
    step_results.delete();
    if (b == CH_NUL) begin
      close_payload();
      clear_payload();
      if (!last) scan_phase = SETTLED;
    end else begin
      consume(b);
      if (last) begin
        close_payload();
        clear_payload();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  function automatic void note_mismatch(input string what, input jkv_pkg::result_t want,
                                        input jkv_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $write("mismatch (%s): expected kind=%0d char=%02h status=%0d value=%0d, ",
             what, want.result_kind, want.string_char, want.status_code, want.number_value);
      $display("got kind=%0d char=%02h status=%0d value=%0d",
               got.result_kind, got.string_char, got.status_code, got.number_value);
    end
  endfunction

  function automatic void check_result(input jkv_pkg::result_t got);
    jkv_pkg::result_t want;
    if (awaited.size() == 0) begin
      note_mismatch("nothing awaited", NO_RESULT, got);
    end else begin
      want = awaited.pop_front();
      if (got.result_kind !== want.result_kind || got.string_char !== want.string_char ||
          got.status_code !== want.status_code || got.number_value !== want.number_value)
        note_mismatch("field differs", want, got);
    end
  endfunction

  // Both channels are observed at the rising edge. A byte is predicted before any result of
  // the same edge is checked, so a result that follows its byte closely still finds its
  // expectation. The watchdog counts edges at which neither channel moves a transaction.
  // The predictor starts over while reset is held.
  always @(posedge clk) begin : observer
    logic             moved;
    jkv_pkg::result_t got;
    if (rst) begin
      clear_payload();
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (payload_ch.valid && payload_ch.ready) begin
        moved = 1'b1;
        extractor_step(payload_ch.payload_byte, payload_ch.payload_last);
        if (row_typed) awaited.push_back(row_want);
        else foreach (step_results[j]) awaited.push_back(step_results[j]);
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        got = '{result_ch.result_kind, result_ch.string_char, result_ch.status_code,
                result_ch.number_value};
        check_result(got);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result side: holds ready low for a random number of cycles before each transaction,
  // with occasional long stretches where it never stalls.
  // ---------------------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    result_ch.ready = 1'b0;
    sink_burst = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Payload side
  // ---------------------------------------------------------------------------------------

  // Presents one byte after a random gap and returns at the falling edge after it was taken.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input jkv_pkg::result_t want);
    int gap;
    gap = source_burst ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      payload_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_typed = typed;
    row_want  = want;
    payload_ch.valid        <= 1'b1;
    payload_ch.payload_byte <= b;
    payload_ch.payload_last <= last;
    do @(posedge clk); while (!payload_ch.ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every awaited result is in, then lets the pipeline settle,
  // since a byte that causes no result may still be in flight.
  task automatic wait_for_drain();
    payload_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    wait_for_drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_VALUE_MODE: cfg_mode     = value[0];
      REG_KEY_LENGTH: cfg_key_len  = value[4:0];
      REG_KEY_LOW:    cfg_key_lo   = value;
      REG_KEY_HIGH:   cfg_key_hi   = value;
      REG_CAPACITY:   cfg_capacity = value[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Key characters are mostly printable and never zero, so the key can actually be found;
  // now and then a raw word lets every register bit toggle.
  function automatic logic [63:0] random_key_word();
    logic [63:0] w;
    int i;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    for (i = 0; i < 8; i++)
      w[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(33, 126));
    return w;
  endfunction

  function automatic logic [63:0] random_register_value(input logic [2:0] idx);
    case (idx)
      REG_VALUE_MODE: return 64'($urandom_range(0, 1));
      REG_KEY_LENGTH: return 64'($urandom_range(0, 31));
      REG_CAPACITY:   return 64'($urandom_range(0, 511));
      default:        return random_key_word();
    endcase
  endfunction

  // Each phase pairs the mode with a key length and capacity that step through the extremes,
  // including the out-of-range values that must clamp.
  task automatic program_phase(input int phase_no);
    logic [63:0] klen;
    logic [63:0] cap;
    case (phase_no % 7)
      0: klen = 64'd1;
      1: klen = 64'd16;
      2: klen = 64'd0;
      3: klen = 64'd31;
      4: klen = 64'd17;
      5: klen = 64'd2;
      default: klen = 64'($urandom_range(1, 16));
    endcase
    case ((phase_no / 2) % 6)
      0: cap = 64'd0;
      1: cap = 64'd1;
      2: cap = 64'd2;
      3: cap = 64'd256;
      4: cap = 64'd511;
      default: cap = 64'($urandom_range(3, 40));
    endcase
    write_register(REG_VALUE_MODE, 64'(phase_no % 2));
    write_register(REG_KEY_LENGTH, klen);
    write_register(REG_KEY_LOW, random_key_word());
    write_register(REG_KEY_HIGH, random_key_word());
    write_register(REG_CAPACITY, cap);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return 8'($urandom_range(1, 255));
      1: return CH_QUOTE;
      2: return CH_COLON;
      3: return CH_SPACE;
      4: return CH_ZERO + 8'($urandom_range(0, 9));
      5: return key_byte($urandom_range(0, key_span() - 1));
      6: return CH_COMMA;
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  function automatic void push_number_value();
    int n;
    logic nines;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 5);
    nines = ($urandom_range(0, 7) == 0);
    repeat (n) outgoing.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 1) outgoing.push_back(CH_COMMA);
  endfunction

  // String values are usually short; once in a while they run right up to the capacity.
  function automatic void push_string_value();
    int n;
    logic [7:0] c;
    outgoing.push_back(CH_QUOTE);
    if (capacity_span() > 0 && $urandom_range(0, 15) == 0)
      n = capacity_span() - 1 + $urandom_range(0, 1);
    else
      n = $urandom_range(0, 6);
    repeat (n) begin
      do c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(97, 122));
      while (c == CH_QUOTE);
      outgoing.push_back(c);
    end
    if ($urandom_range(0, 7) != 0) outgoing.push_back(CH_QUOTE);
  endfunction

  // Most payloads carry the quoted key and a value of the configured kind; the rest are near
  // misses (a corrupted key, a missing colon, the wrong value kind) or plain noise. A few get
  // a zero byte dropped in somewhere.
  function automatic void build_payload();
    int klen;
    int i;
    outgoing.delete();
    klen = key_span();
    repeat ($urandom_range(0, 3)) outgoing.push_back(noise_byte());
    if ($urandom_range(0, 9) < 8) begin
      outgoing.push_back(CH_QUOTE);
      for (i = 0; i < klen; i++) outgoing.push_back(key_byte(i));
      if ($urandom_range(0, 7) == 0)
        outgoing[$urandom_range(outgoing.size() - klen, outgoing.size() - 1)] = noise_byte();
      outgoing.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 2)) outgoing.push_back(CH_SPACE);
      outgoing.push_back(($urandom_range(0, 7) == 0) ? noise_byte() : CH_COLON);
      repeat ($urandom_range(0, 2)) outgoing.push_back(CH_SPACE);
      if (cfg_mode ^ ($urandom_range(0, 7) == 0)) push_string_value();
      else push_number_value();
    end
    repeat ($urandom_range(0, 3)) outgoing.push_back(noise_byte());
    if (outgoing.size() == 0) outgoing.push_back(noise_byte());
    if ($urandom_range(0, 15) == 0) outgoing[$urandom_range(0, outgoing.size() - 1)] = CH_NUL;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------

  initial begin : stimulus
    int phase_no;
    int i;
    int cut;
    logic [2:0] reg_pick;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_VALUE_MODE;
    cfg_data       = 64'd0;
    payload_ch.valid        = 1'b0;
    payload_ch.payload_byte = 8'h00;
    payload_ch.payload_last = 1'b0;
    row_typed      = 1'b0;
    row_want       = NO_RESULT;
    source_burst   = 1'b0;
    random_items   = 0;
    cfg_mode       = 1'b0;
    cfg_key_len    = 5'd1;
    cfg_key_lo     = 64'd0;
    cfg_key_hi     = 64'd0;
    cfg_capacity   = 9'd256;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) write_register(plan[r].reg_index, plan[r].reg_value);
      else send_byte(plan[r].data, plan[r].last, plan[r].typed, plan[r].want);
    end

    // Random payloads, one configuration phase after another. Every phase starts from an
    // idle block, so the sender pauses until every awaited result is in. Now and then a
    // register is rewritten part way through a payload, again with the block drained.
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      program_phase(phase_no);
      repeat ($urandom_range(4, 10)) begin
        build_payload();
        source_burst = ($urandom_range(0, 5) == 0);
        cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, outgoing.size() - 1) : -1;
        for (i = 0; i < outgoing.size(); i++) begin
          if (i == cut && i > 0) begin
            reg_pick = 3'($urandom_range(0, 4));
            write_register(reg_pick, random_register_value(reg_pick));
          end
          send_byte(outgoing[i], i == outgoing.size() - 1, 1'b0, NO_RESULT);
          random_items++;
        end
      end
      phase_no++;
    end

    wait_for_drain();
    if (mismatch_count == 0 && awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* json_key_value_extractor_unit.f */
rtl/jkv_pkg.sv
rtl/jkv_in_if.sv
rtl/jkv_out_if.sv
rtl/jkv_key_match.sv
rtl/jkv_result_queue.sv
rtl/json_key_value_extractor_unit.sv
test/json_key_value_extractor_unit_test.sv
